// ===== src/xks_pkg.sv =====
package xks_pkg;

    localparam int NUM_KEYS = 256;
    localparam int MAX_LEN  = 4096;
    localparam int BYTE_W   = 8;
    localparam int KEY_W    = 8;
    localparam int SCORE_W  = 13;
    localparam int IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] LOWER_RESET = BYTE_W'(48);
    localparam logic [BYTE_W-1:0] UPPER_RESET = BYTE_W'(122);
    localparam logic [SCORE_W-1:0] SCORE_MAX  = SCORE_W'(MAX_LEN);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_BOUND = 1'b0,
        REG_UPPER_BOUND = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] lower;
        logic [BYTE_W-1:0] upper;
    } bounds_t;

    typedef struct packed {
        logic count_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

// ===== src/xks_in_if.sv =====
interface xks_in_if;
    import xks_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] cipher_byte;
    logic              last_byte;

    modport source (output valid, output cipher_byte, output last_byte, input ready);
    modport sink (input valid, input cipher_byte, input last_byte, output ready);
endinterface

// ===== src/xks_out_if.sv =====
interface xks_out_if;
    import xks_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   best_key;
    logic [SCORE_W-1:0] best_score;

    modport source (output valid, output best_key, output best_score, input ready);
    modport sink (input valid, input best_key, input best_score, output ready);
endinterface

// ===== src/xks_cell.sv =====
module xks_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [xks_pkg::KEY_W-1:0]   key_idx,
    input  logic [xks_pkg::BYTE_W-1:0]  cipher_byte,
    input  xks_pkg::bounds_t            bounds,
    input  xks_pkg::cell_ctrl_t         ctrl,
    input  logic [xks_pkg::SCORE_W-1:0] shift_in,
    output logic [xks_pkg::SCORE_W-1:0] score
);
    import xks_pkg::*;

    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic [BYTE_W-1:0]  plain;
    logic               hit;

    assign plain = cipher_byte ^ BYTE_W'(key_idx);
    assign hit   = (plain > bounds.lower) && (plain < bounds.upper);

    always_comb
    begin
        score_next = score_reg;
        if (ctrl.shift_en)
        begin
            score_next = shift_in;
        end
        else if (ctrl.count_en && hit && (score_reg < SCORE_MAX))
        begin
            score_next = score_reg + SCORE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
        end
        else
        begin
            score_reg <= score_next;
        end
    end

    assign score = score_reg;
endmodule

// ===== src/xks_argmax.sv =====
module xks_argmax (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [xks_pkg::SCORE_W-1:0] head_score,
    output logic                        shift_en,
    output logic                        busy,
    xks_out_if.source                   result
);
    import xks_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_WAIT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_KEYS - 1);

    state_t             state_reg;
    logic [IDX_W-1:0]   step_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic               out_valid_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic [SCORE_W-1:0] out_score_reg;

    logic               take;
    logic [KEY_W-1:0]   cand_key;
    logic [SCORE_W-1:0] cand_score;
    logic               out_free;
    logic               load_out;

    // running maximum, strict compare keeps the lowest key on ties
    assign take       = (step_reg == '0) || (head_score > best_score_reg);
    assign cand_key   = take ? KEY_W'(step_reg) : best_key_reg;
    assign cand_score = take ? head_score : best_score_reg;
    assign out_free   = !out_valid_reg || result.ready;
    assign load_out   = out_free && (((state_reg == ST_DRAIN) && (step_reg == LAST_STEP))
                                     || (state_reg == ST_WAIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            best_key_reg   <= '0;
            best_score_reg <= '0;
            out_key_reg    <= '0;
            out_score_reg  <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DRAIN;
                        step_reg  <= '0;
                    end
                end
                ST_DRAIN:
                begin
                    best_key_reg   <= cand_key;
                    best_score_reg <= cand_score;
                    step_reg       <= step_reg + IDX_W'(1);
                    if (step_reg == LAST_STEP)
                    begin
                        if (out_free)
                        begin
                            out_key_reg   <= cand_key;
                            out_score_reg <= cand_score;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT:
                begin
                    if (out_free)
                    begin
                        out_key_reg   <= best_key_reg;
                        out_score_reg <= best_score_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign shift_en          = (state_reg == ST_DRAIN);
    assign busy              = (state_reg != ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.best_key   = out_key_reg;
    assign result.best_score = out_score_reg;
endmodule

// ===== src/single_byte_xor_key_search_top.sv =====
// single-byte xor key search
// byte_stream carries one ciphertext byte per request with a last_byte flag;
// result carries best_key and best_score, one request per message.
// configuration: wr_en, wr_index and wr_data write lower_bound (index 0) or
// upper_bound (index 1) at the clock edge; no read-back.
// a row of NUM_KEYS cells keeps one saturating score per key; each cell counts
// an accepted byte whose plaintext lies strictly between the bounds, and bytes
// are taken one per cycle while no drain or held result blocks the input.
// after the last byte the scores shift along the row towards cell 0, one key
// per cycle, past a running maximum; no byte is taken during this drain. the
// shift fills the row with zeros, so scores are clear afterwards. the result is
// valid in the cycle after the drain if the output register is free then.
// a result waits in an output register while the receiver stalls; the next
// message may stream in meanwhile, but if its drain ends before that register
// is free, its result is held and no byte is taken until the register empties.
// reset clears all scores and the output, and loads bounds 48 and 122.
module single_byte_xor_key_search_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [xks_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [xks_pkg::BYTE_W-1:0]    wr_data,
    xks_in_if.sink                        byte_stream,
    xks_out_if.source                     result
);
    import xks_pkg::*;

    bounds_t            bounds_reg;
    logic [SCORE_W-1:0] score_w [NUM_KEYS + 1];
    cell_ctrl_t         ctrl;
    logic               busy;
    logic               shift_en;
    logic               in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.lower <= LOWER_RESET;
            bounds_reg.upper <= UPPER_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_LOWER_BOUND: bounds_reg.lower <= wr_data;
                REG_UPPER_BOUND: bounds_reg.upper <= wr_data;
                default:         bounds_reg       <= bounds_reg;
            endcase
        end
    end

    assign byte_stream.ready = !busy;
    assign in_fire           = byte_stream.valid && byte_stream.ready;
    assign ctrl              = '{count_en: in_fire, shift_en: shift_en};
    assign score_w[NUM_KEYS] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_KEYS; g++)
        begin : g_cell
            xks_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .key_idx     (KEY_W'(g)),
                .cipher_byte (byte_stream.cipher_byte),
                .bounds      (bounds_reg),
                .ctrl        (ctrl),
                .shift_in    (score_w[g + 1]),
                .score       (score_w[g])
            );
        end
    endgenerate

    xks_argmax u_argmax (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_fire && byte_stream.last_byte),
        .head_score (score_w[0]),
        .shift_en   (shift_en),
        .busy       (busy),
        .result     (result)
    );

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_stream.valid && byte_stream.ready && byte_stream.last_byte)
        |=> !byte_stream.ready)
        else $error("input taken during drain");

    a_head_sat: assert property (@(posedge clk) disable iff (!rst_n)
        score_w[0] <= SCORE_MAX)
        else $error("score above saturation limit");

    a_out_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.best_score <= SCORE_MAX))
        else $error("reported score above saturation limit");

    a_no_count_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |-> !in_fire)
        else $error("count and shift in one cycle");
endmodule
